// File: hw/rtl/hermite_waypoint_interpolator_core_defines.svh
// Assertion macros for the waypoint interpolator checker.
// Expects signals clk and rst in the scope of use.
`ifndef HERMITE_WAYPOINT_INTERPOLATOR_CORE_DEFINES_SVH
`define HERMITE_WAYPOINT_INTERPOLATOR_CORE_DEFINES_SVH

// Checked out of reset only.
`define HWI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define HWI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/hwi_pkg.sv
// Shared types and constants of the Hermite waypoint interpolator.
// No dependencies.
`timescale 1ns / 1ps

package hwi_pkg;

  localparam int POS_W  = 32;
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int TPS_W  = 8;
  localparam int PH_W   = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [PH_W-1:0]  PH_ONE   = 17'h10000;
  localparam logic [TPS_W-1:0] TPS_RST  = 8'd10;
  localparam logic [PH_W-1:0]  PINC_RST = 17'd6554;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WAYPOINT_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEGMENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCREMENT   = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        waypoint_index;
    logic signed [POS_W-1:0] shoulder_position;
    logic signed [POS_W-1:0] shoulder_velocity;
    logic signed [POS_W-1:0] elbow_position;
    logic signed [POS_W-1:0] elbow_velocity;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] shoulder_setpoint;
    logic signed [POS_W-1:0] elbow_setpoint;
    logic                    done_res;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [PH_W-1:0]      value;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] sh_pos;
    logic signed [POS_W-1:0] sh_vel;
    logic signed [POS_W-1:0] el_pos;
    logic signed [POS_W-1:0] el_vel;
  } entry_t;

  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_SS,
    MOP_UU,
    MOP_B00,
    MOP_B01,
    MOP_B10,
    MOP_B11,
    MOP_T0,
    MOP_T1,
    MOP_T2,
    MOP_T3
  } mop_t;

  typedef struct packed {
    mop_t op;
    logic ax;
    logic ld_a;
    logic ld_b;
    logic clr;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic done;
  } stat_t;

endpackage

// File: hw/rtl/hwi_stream_if.sv
// Valid/ready channel carrying one payload of a given type.
// No dependencies.
`timescale 1ns / 1ps

interface hwi_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/hwi_seq.sv
// Sequencer: waypoint table memory, playback state and multiply schedule.
// Depends on hwi_pkg.
`timescale 1ns / 1ps

module hwi_seq #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  hwi_pkg::item_t           item,
  input  logic [hwi_pkg::CNT_W-1:0] waypoint_count,
  input  logic [hwi_pkg::TPS_W-1:0] ticks_per_segment,
  input  logic [hwi_pkg::PH_W-1:0]  phase_increment,
  input  logic                     out_free,
  output hwi_pkg::cmd_t            cmd,
  output logic [hwi_pkg::PH_W-1:0]  phase_s,
  output hwi_pkg::entry_t          entry,
  output hwi_pkg::stat_t           stat
);
  import hwi_pkg::*;

  localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int STEPS      = 14;
  localparam int STEP_W     = $clog2(STEPS);
  localparam int ELBOW_STEP = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_LD_B,
    ST_CALC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  seg;
  logic [TPS_W-1:0]  tick;
  logic [PH_W-1:0]   phase;
  logic              finished;

  entry_t            mem [TABLE_DEPTH];
  logic [AW-1:0]     raddr;
  logic              accept;
  logic              wr_en;
  logic [CNT_W-1:0]  count;
  logic              more;
  logic [PH_W:0]     phase_sum;
  logic [TPS_W:0]    tick_inc;

  function automatic mop_t step_op(input logic [STEP_W-1:0] s);
    mop_t m;
    unique case (s) inside
      4'd0:         m = MOP_SS;
      4'd1:         m = MOP_UU;
      4'd2:         m = MOP_B01;
      4'd3:         m = MOP_B11;
      4'd4:         m = MOP_B00;
      4'd5:         m = MOP_B10;
      4'd6, 4'd10:  m = MOP_T0;
      4'd7, 4'd11:  m = MOP_T1;
      4'd8, 4'd12:  m = MOP_T2;
      4'd9, 4'd13:  m = MOP_T3;
      default:      m = MOP_NONE;
    endcase
    return m;
  endfunction

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign wr_en      = accept && (item.op == OP_LOAD)
                      && (32'(item.waypoint_index) < 32'(TABLE_DEPTH));
  assign count      = (32'(waypoint_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                                 : waypoint_count;
  assign more       = (({1'b0, seg} + (CNT_W+1)'(1)) < {1'b0, count});
  assign raddr      = (state == ST_RD_A) ? AW'(seg) : AW'(seg + CNT_W'(1));
  assign phase_sum  = {1'b0, phase} + {1'b0, phase_increment};
  assign tick_inc   = {1'b0, tick} + (TPS_W+1)'(1);
  assign phase_s    = phase;

  always_comb begin
    cmd.op   = (state == ST_CALC) ? step_op(step) : MOP_NONE;
    cmd.ax   = (step >= STEP_W'(ELBOW_STEP));
    cmd.ld_a = (state == ST_RD_B);
    cmd.ld_b = (state == ST_LD_B);
    cmd.clr  = accept && (item.op == OP_START);
    cmd.fin  = finished;
    stat.emit = (state == ST_EMIT) && out_free;
    stat.done = finished;
  end

  // waypoint table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(item.waypoint_index)] <= '{sh_pos: item.shoulder_position,
                                         sh_vel: item.shoulder_velocity,
                                         el_pos: item.elbow_position,
                                         el_vel: item.elbow_velocity};
    end
    entry <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      seg      <= '0;
      tick     <= '0;
      phase    <= '0;
      finished <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (item.op)
              OP_START: begin
                seg      <= '0;
                tick     <= '0;
                phase    <= '0;
                finished <= 1'b0;
              end
              OP_TICK: begin
                step <= '0;
                if (!finished && tick == '0) begin
                  if (more) begin
                    state <= ST_RD_A;
                  end else begin
                    finished <= 1'b1;
                    state    <= ST_EMIT;
                  end
                end else if (finished) begin
                  state <= ST_EMIT;
                end else begin
                  state <= ST_CALC;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RD_A: state <= ST_RD_B;
        ST_RD_B: state <= ST_LD_B;
        ST_LD_B: begin
          seg   <= seg + CNT_W'(1);
          phase <= '0;
          step  <= '0;
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (step == STEP_W'(STEPS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_DRAIN: state <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (!finished) begin
              phase <= (phase_sum > {1'b0, PH_ONE}) ? PH_ONE : phase_sum[PH_W-1:0];
              tick  <= (tick_inc >= {1'b0, ticks_per_segment}) ? '0 : tick_inc[TPS_W-1:0];
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/hwi_datapath.sv
// Datapath: segment endpoints, shared multiplier, basis registers and
// per-axis accumulators with rounding and saturation. Depends on hwi_pkg.
`timescale 1ns / 1ps

module hwi_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  hwi_pkg::cmd_t                  cmd,
  input  logic [hwi_pkg::PH_W-1:0]        phase_s,
  input  hwi_pkg::entry_t                entry,
  output logic signed [hwi_pkg::POS_W-1:0] shoulder,
  output logic signed [hwi_pkg::POS_W-1:0] elbow
);
  import hwi_pkg::*;

  localparam int MA_W   = 34;
  localparam int MB_W   = 32;
  localparam int PROD_W = MA_W + MB_W;
  localparam int SQ_W   = 33;
  localparam int BW     = 31;
  localparam int BR_W   = 51;
  localparam int CO_W   = 18;

  localparam logic [BR_W-1:0]          BASIS_RND = 51'h20000;
  localparam logic signed [PROD_W-1:0] ACC_RND   = 66'sh20000000;
  localparam logic [CO_W-1:0]          CO01_BASE = 18'd196608;
  localparam logic signed [POS_W-1:0]  POS_MAX   = 32'sh7FFFFFFF;
  localparam logic signed [POS_W-1:0]  POS_MIN   = 32'sh80000000;

  typedef struct packed {
    logic signed [POS_W-1:0] p0;
    logic signed [POS_W-1:0] p1;
    logic signed [POS_W-1:0] v0;
    logic signed [POS_W-1:0] v1;
  } axis_ep_t;

  axis_ep_t                  ep [2];
  axis_ep_t                  sel;
  logic [PH_W-1:0]           u;
  logic [CO_W-1:0]           co00;
  logic [CO_W-1:0]           co01;
  logic signed [POS_W:0]     nv1;
  logic signed [MA_W-1:0]    ma;
  logic signed [MB_W-1:0]    mb;
  logic signed [PROD_W-1:0]  prod;
  mop_t                      op_d;
  logic                      ax_d;
  logic [SQ_W-1:0]           ss;
  logic [SQ_W-1:0]           uu;
  logic [BW-1:0]             b00;
  logic [BW-1:0]             b01;
  logic [BW-1:0]             b10;
  logic [BW-1:0]             b11;
  logic [BR_W-1:0]           bround;
  logic signed [PROD_W-1:0]  acc [2];

  function automatic logic signed [POS_W-1:0] sat_q16(input logic signed [PROD_W-1:0] v);
    logic [4:0] hi;
    hi = v[PROD_W-1:PROD_W-5];
    if ((&hi) || !(|hi)) begin
      return v[61:30];
    end
    return v[PROD_W-1] ? POS_MIN : POS_MAX;
  endfunction

  assign sel    = ep[cmd.ax];
  assign u      = PH_ONE - phase_s;
  assign co00   = {1'b0, PH_ONE} + {phase_s, 1'b0};
  assign co01   = CO01_BASE - {phase_s, 1'b0};
  assign nv1    = -{sel.v1[POS_W-1], sel.v1};
  assign bround = prod[BR_W-1:0] + BASIS_RND;

  always_comb begin
    case (cmd.op)
      MOP_SS: begin
        ma = {17'b0, phase_s};
        mb = {15'b0, phase_s};
      end
      MOP_UU: begin
        ma = {17'b0, u};
        mb = {15'b0, u};
      end
      MOP_B00: begin
        ma = {1'b0, uu};
        mb = {14'b0, co00};
      end
      MOP_B01: begin
        ma = {1'b0, ss};
        mb = {14'b0, co01};
      end
      MOP_B10: begin
        ma = {1'b0, uu};
        mb = {15'b0, phase_s};
      end
      MOP_B11: begin
        ma = {1'b0, ss};
        mb = {15'b0, u};
      end
      MOP_T0: begin
        ma = {{2{sel.p0[POS_W-1]}}, sel.p0};
        mb = {1'b0, b00};
      end
      MOP_T1: begin
        ma = {{2{sel.p1[POS_W-1]}}, sel.p1};
        mb = {1'b0, b01};
      end
      MOP_T2: begin
        ma = {{2{sel.v0[POS_W-1]}}, sel.v0};
        mb = {1'b0, b10};
      end
      MOP_T3: begin
        ma = {nv1[POS_W], nv1};
        mb = {1'b0, b11};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      ep[0] <= '0;
      ep[1] <= '0;
    end else if (cmd.ld_a) begin
      ep[0].p0 <= entry.sh_pos;
      ep[0].v0 <= entry.sh_vel;
      ep[1].p0 <= entry.el_pos;
      ep[1].v0 <= entry.el_vel;
    end else if (cmd.ld_b) begin
      ep[0].p1 <= entry.sh_pos;
      ep[0].v1 <= entry.sh_vel;
      ep[1].p1 <= entry.el_pos;
      ep[1].v1 <= entry.el_vel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_d <= MOP_NONE;
    end else begin
      op_d <= cmd.op;
    end
    ax_d <= cmd.ax;
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    case (op_d)
      MOP_SS:  ss  <= prod[SQ_W-1:0];
      MOP_UU:  uu  <= prod[SQ_W-1:0];
      MOP_B00: b00 <= bround[48:18];
      MOP_B01: b01 <= bround[48:18];
      MOP_B10: b10 <= bround[48:18];
      MOP_B11: b11 <= bround[48:18];
      MOP_T0:  acc[ax_d] <= prod + ACC_RND;
      MOP_T1, MOP_T2, MOP_T3: acc[ax_d] <= acc[ax_d] + prod;
      default: ;
    endcase
  end

  assign shoulder = cmd.fin ? ep[0].p1 : sat_q16(acc[0]);
  assign elbow    = cmd.fin ? ep[1].p1 : sat_q16(acc[1]);

endmodule

// File: hw/rtl/hermite_waypoint_interpolator_core.sv
// Top level of the two-axis cubic Hermite waypoint interpolator.
// Depends on hwi_pkg, hwi_stream_if, hwi_seq and hwi_datapath.
//
// Channels: req carries items (op load, start or tick, with table index and
// shoulder/elbow position and velocity), rsp carries one setpoint pair and a
// done flag per tick, cfg writes waypoint_count, ticks_per_segment and
// phase_increment by index. cfg is always ready. All transactions complete
// on a rising edge with valid and ready high.
// Load, start and unused ops complete without leaving the idle state. A tick
// inside a segment runs its multiply steps through the one shared multiplier,
// then drains the product and accumulator stages: the result is registered in
// the emit state, req goes ready at that same edge and the next transaction
// can be taken after it. A tick at a segment boundary first passes RD_A, RD_B
// and LD_B for the two reads of the waypoint table memory. A tick after
// playback ends goes straight to the emit state.
// Reset restores the register defaults and rewinds playback; the table
// keeps its contents and is defined only where loaded.
// A stalled rsp holds its result; the pending tick waits in its last step
// and req stays low until the result register is free.
`timescale 1ns / 1ps

module hermite_waypoint_interpolator_core #(
  parameter int TABLE_DEPTH = 256
) (
  input logic          clk,
  input logic          rst,
  hwi_stream_if.sink   req,
  hwi_stream_if.source rsp,
  hwi_stream_if.sink   cfg
);
  import hwi_pkg::*;

  logic [CNT_W-1:0] waypoint_count;
  logic [TPS_W-1:0] ticks_per_segment;
  logic [PH_W-1:0]  phase_increment;

  cmd_t                    cmd;
  stat_t                   stat;
  entry_t                  entry;
  logic [PH_W-1:0]         phase_s;
  logic signed [POS_W-1:0] shoulder;
  logic signed [POS_W-1:0] elbow;
  logic                    out_valid;
  result_t                 out_q;
  logic                    out_free;

  assign cfg.ready = 1'b1;
  assign out_free  = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_count    <= '0;
      ticks_per_segment <= TPS_RST;
      phase_increment   <= PINC_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        CFG_WAYPOINT_COUNT:    waypoint_count    <= cfg.data.value[CNT_W-1:0];
        CFG_TICKS_PER_SEGMENT: ticks_per_segment <= cfg.data.value[TPS_W-1:0];
        CFG_PHASE_INCREMENT:   phase_increment   <= cfg.data.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (stat.emit) begin
      out_q <= '{shoulder_setpoint: shoulder, elbow_setpoint: elbow, done_res: stat.done};
    end
  end

  hwi_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (req.valid),
    .item_ready       (req.ready),
    .item             (req.data),
    .waypoint_count   (waypoint_count),
    .ticks_per_segment(ticks_per_segment),
    .phase_increment  (phase_increment),
    .out_free         (out_free),
    .cmd              (cmd),
    .phase_s          (phase_s),
    .entry            (entry),
    .stat             (stat)
  );

  hwi_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .phase_s (phase_s),
    .entry   (entry),
    .shoulder(shoulder),
    .elbow   (elbow)
  );

endmodule

// File: hw/rtl/hwi_checker.sv
// Port-level checks for the waypoint interpolator, bound to the top level.
// Depends on hwi_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "hermite_waypoint_interpolator_core_defines.svh"

module hwi_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic [1:0]       req_op,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input hwi_pkg::result_t rsp_data
);
  import hwi_pkg::*;

  `HWI_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")
  `HWI_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_data), "result changed while stalled")
  `HWI_ASSERT(a_tick_busy, req_valid && req_ready && req_op == OP_TICK |=> !req_ready, "new item taken during a tick")
  `HWI_ASSERT_ALWAYS(a_rst_clear, rst |=> !rsp_valid, "result valid after reset")

endmodule

bind hermite_waypoint_interpolator_core hwi_checker u_hwi_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .req_op   (req.data.op),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_data (rsp.data)
);

// File: tb/sv/hwi_setpoint_checker.sv
// Scoreboard for the Hermite waypoint interpolator: watches req, rsp and cfg,
// predicts each tick's setpoint pair and compares it field by field.
// Depends on hwi_pkg and hwi_stream_if.
`timescale 1ns / 1ps

module hwi_setpoint_checker
  import hwi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  hwi_stream_if req,
  hwi_stream_if rsp,
  hwi_stream_if cfg,
  output int    fail_count,
  output int    outstanding,
  output int    checked_count
);

  localparam int DEPTH = 256;
  localparam logic signed [95:0] SAT_HI = 96'sd2147483647;
  localparam logic signed [95:0] SAT_LO = -96'sd2147483648;
  localparam logic signed [95:0] HALF_LSB = 96'sd536870912;

  entry_t                  wp_table [DEPTH];
  logic signed [POS_W-1:0] seg_ends [8];
  logic [CNT_W-1:0]        seg_num;
  logic [TPS_W-1:0]        tick_cnt;
  logic [PH_W-1:0]         phase;
  logic                    finished;
  logic [CNT_W-1:0]        reg_count;
  logic [TPS_W-1:0]        reg_tps;
  logic [PH_W-1:0]         reg_pinc;
  result_t                 setpoint_q [$];

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 200) $display("%0t ns  mismatch: %s", $realtime, msg);
  endtask

  // Exact weighted sum at 2^-46 scale, rounded half up to Q16.16, saturated.
  function automatic logic signed [POS_W-1:0] hermite_point(
    input logic signed [POS_W-1:0] p0, p1, v0, v1, input logic [PH_W-1:0] s);
    logic [63:0]        sv, uv, h00, h01, h10, h11;
    logic signed [95:0] acc;
    sv  = 64'(s);
    uv  = 64'd65536 - sv;
    h00 = ((64'd65536 + 2 * sv) * uv * uv + 64'd131072) >> 18;
    h01 = ((64'd196608 - 2 * sv) * sv * sv + 64'd131072) >> 18;
    h10 = (sv * uv * uv + 64'd131072) >> 18;
    h11 = (uv * sv * sv + 64'd131072) >> 18;
    acc = $signed({32'd0, h00}) * p0 + $signed({32'd0, h01}) * p1
        + $signed({32'd0, h10}) * v0 - $signed({32'd0, h11}) * v1 + HALF_LSB;
    acc = acc >>> 30;
    if (acc > SAT_HI) acc = SAT_HI;
    if (acc < SAT_LO) acc = SAT_LO;
    return acc[POS_W-1:0];
  endfunction

  task automatic rewind();
    foreach (seg_ends[k]) seg_ends[k] = '0;
    seg_num  = '0;
    tick_cnt = '0;
    phase    = '0;
    finished = 1'b0;
  endtask

  task automatic predict_setpoint(output result_t r);
    int unsigned eff, np;
    entry_t      a, b;
    eff = (reg_count > 9'd256) ? 256 : reg_count;
    if (!finished && tick_cnt == 0) begin
      if (seg_num + 1 < eff) begin
        a = wp_table[seg_num];
        b = wp_table[seg_num + 1];
        seg_ends = '{a.sh_pos, b.sh_pos, a.sh_vel, b.sh_vel,
                     a.el_pos, b.el_pos, a.el_vel, b.el_vel};
        seg_num  = CNT_W'(seg_num + 1);
        phase    = '0;
      end else begin
        finished = 1'b1;
      end
    end
    if (finished) begin
      r.shoulder_setpoint = seg_ends[1];
      r.elbow_setpoint    = seg_ends[5];
      r.done_res          = 1'b1;
    end else begin
      r.shoulder_setpoint = hermite_point(seg_ends[0], seg_ends[1], seg_ends[2],
                                          seg_ends[3], phase);
      r.elbow_setpoint    = hermite_point(seg_ends[4], seg_ends[5], seg_ends[6],
                                          seg_ends[7], phase);
      r.done_res          = 1'b0;
      np    = phase + reg_pinc;
      phase = (np > 65536) ? PH_ONE : np[PH_W-1:0];
      tick_cnt = (tick_cnt + 1 >= reg_tps) ? '0 : TPS_W'(tick_cnt + 1);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      reg_count     = '0;
      reg_tps       = TPS_RST;
      reg_pinc      = PINC_RST;
      rewind();
      setpoint_q.delete();
      fail_count    = 0;
      checked_count = 0;
      outstanding  <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.data.index)
          CFG_WAYPOINT_COUNT:    reg_count = cfg.data.value[CNT_W-1:0];
          CFG_TICKS_PER_SEGMENT: reg_tps   = cfg.data.value[TPS_W-1:0];
          CFG_PHASE_INCREMENT:   reg_pinc  = cfg.data.value;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        if (setpoint_q.size() == 0) begin
          flag_error($sformatf("setpoint transaction with no tick pending (%h %h %b)",
                               got.shoulder_setpoint, got.elbow_setpoint, got.done_res));
        end else begin
          want = setpoint_q.pop_front();
          checked_count++;
          if (got.shoulder_setpoint !== want.shoulder_setpoint)
            flag_error($sformatf("result %0d shoulder_setpoint %h, expected %h",
                                 checked_count, got.shoulder_setpoint,
                                 want.shoulder_setpoint));
          if (got.elbow_setpoint !== want.elbow_setpoint)
            flag_error($sformatf("result %0d elbow_setpoint %h, expected %h",
                                 checked_count, got.elbow_setpoint, want.elbow_setpoint));
          if (got.done_res !== want.done_res)
            flag_error($sformatf("result %0d done_res %b, expected %b",
                                 checked_count, got.done_res, want.done_res));
        end
      end
      if (req.valid && req.ready) begin
        case (req.data.op)
          OP_LOAD: begin
            wp_table[req.data.waypoint_index] = '{req.data.shoulder_position,
                                                  req.data.shoulder_velocity,
                                                  req.data.elbow_position,
                                                  req.data.elbow_velocity};
          end
          OP_START: rewind();
          OP_TICK: begin
            predict_setpoint(want);
            setpoint_q = {setpoint_q, want};
          end
          default: ;
        endcase
      end
      outstanding <= setpoint_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for hermite_waypoint_interpolator_core: clock, reset, stimulus
// with random flow control, and the final verdict.
// Depends on hwi_pkg, hwi_stream_if, the core and hwi_setpoint_checker.
`timescale 1ns / 1ps

module tb_top;
  import hwi_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_ITEMS   = 500;
  localparam logic [1:0]           OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [POS_W-1:0] POS_TOP    = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_BOTTOM = 32'sh8000_0000;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} stall_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic hold_req;
  int   fail_count, outstanding, checked_count;
  int   idle_cycles = 0;
  int   item_count = 0;
  int   settings_count = 0;
  int   burst_left = 0;
  bit   bursty = 1'b0;

  hwi_stream_if #(.payload_t(item_t))   req_ch ();
  hwi_stream_if #(.payload_t(result_t)) rsp_ch ();
  hwi_stream_if #(.payload_t(cfg_t))    cfg_ch ();

  hermite_waypoint_interpolator_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  hwi_setpoint_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .cfg           (cfg_ch),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("[hermite_waypoint_interpolator_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver back-pressure; a long hold-off is counted here on request.
  initial begin
    stall_mode_t mode;
    int          left, hold;
    bit          hold_done;
    mode      = RDY_ALWAYS;
    left      = 0;
    hold      = 0;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold      = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          RDY_ALWAYS: rsp_ch.ready <= 1'b1;
          RDY_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default:    rsp_ch.ready <= ~rsp_ch.ready;
        endcase
      end
    end
  end

  function automatic item_t make_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                      input logic [POS_W-1:0] sp, sv, ep, ev);
    item_t it;
    it.op                = op;
    it.waypoint_index    = idx;
    it.shoulder_position = sp;
    it.shoulder_velocity = sv;
    it.elbow_position    = ep;
    it.elbow_velocity    = ev;
    return it;
  endfunction

  // Mostly plausible joint values, with extremes and raw words mixed in.
  function automatic logic [POS_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return POS_TOP;
      1:       return POS_BOTTOM;
      2, 3:    return $urandom();
      default: return 32'($urandom_range(0, 2 * (180 << 16))) - 32'(180 << 16);
    endcase
  endfunction

  task automatic send_item(input item_t it);
    if (bursty && burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    if (burst_left > 0) burst_left--;
    item_count++;
  endtask

  task automatic send_op(input logic [1:0] op);
    send_item(make_item(op, IDX_W'($urandom()), $urandom(), $urandom(), $urandom(),
                        $urandom()));
  endtask

  task automatic load_entry(input int idx);
    send_item(make_item(OP_LOAD, IDX_W'(idx), rand_word(), rand_word(), rand_word(),
                        rand_word()));
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PH_W-1:0] val);
    cfg_t c;
    c.index = idx;
    c.value = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Upper bits beyond each register's width are random and must be dropped.
  task automatic configure(input int count, input int tps, input int pinc);
    write_reg(CFG_WAYPOINT_COUNT, {8'($urandom()), 9'(count)});
    write_reg(CFG_TICKS_PER_SEGMENT, {9'($urandom()), 8'(tps)});
    write_reg(CFG_PHASE_INCREMENT, 17'(pinc));
    settings_count++;
  endtask

  initial begin
    int  random_items, phase_no, n, count, tps, pinc, eff, ticks, r;
    bit  full, full_done;
    random_items = 0;
    phase_no     = 0;
    full_done    = 1'b0;
    rst          <= 1'b1;
    hold_req     <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: defaults before any start, extremes with saturation, end hold,
    // restart, and a table too short to play.
    send_op(OP_TICK);
    send_op(OP_UNUSED);
    send_item(make_item(OP_LOAD, 8'd0, POS_TOP, POS_TOP, POS_BOTTOM, POS_BOTTOM));
    send_item(make_item(OP_LOAD, 8'd1, POS_TOP, POS_BOTTOM, POS_BOTTOM, POS_TOP));
    send_item(make_item(OP_LOAD, 8'd2, '0, '0, '0, '0));
    send_item(make_item(OP_LOAD, 8'd3, '1, '1, '1, '1));
    drain_results();
    configure(4, 3, 32768);
    send_op(OP_START);
    repeat (11) send_op(OP_TICK);
    load_entry(255);
    send_op(OP_START);
    send_op(OP_TICK);
    drain_results();
    configure(1, 3, 32768);
    send_op(OP_START);
    repeat (2) send_op(OP_TICK);

    while (random_items < RANDOM_ITEMS) begin
      phase_no++;
      bursty = ($urandom_range(0, 3) != 0);
      full   = !full_done && phase_no >= 3;
      if (full) begin
        n = 256;
      end else begin
        case ($urandom_range(0, 9))
          0:       n = 0;
          1:       n = 1;
          2:       n = $urandom_range(7, 16);
          default: n = $urandom_range(2, 6);
        endcase
      end
      for (int k = 0; k < n; k++) load_entry(k);
      random_items += n;
      drain_results();

      if (full) count = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
      else if (n > 2 && $urandom_range(0, 3) == 0) count = n - 1;
      else count = n;
      if (full) begin
        tps = 1;
      end else begin
        case ($urandom_range(0, 7))
          0:       tps = 0;
          1:       tps = 1;
          2:       tps = 255;
          3:       tps = 2;
          default: tps = $urandom_range(1, 6);
        endcase
      end
      case ($urandom_range(0, 7))
        0:       pinc = 0;
        1:       pinc = 1;
        2:       pinc = 65536;
        3:       pinc = 131071;
        4:       pinc = $urandom_range(1, 65536);
        default: pinc = $urandom_range(8192, 40000);
      endcase
      configure(count, tps, pinc);
      if (phase_no % 4 == 1) write_reg(CFG_SPARE, 17'($urandom()));

      // One phase holds the receiver off while ticks keep coming.
      if (phase_no == 2) hold_req <= 1'b1;
      send_op(OP_START);
      random_items++;
      eff   = (count > 256) ? 256 : count;
      ticks = ((eff > 1) ? (eff - 1) * ((tps == 0) ? 1 : tps) : 0) + $urandom_range(1, 4);
      if (!full && ticks > 40) ticks = $urandom_range(24, 40);
      for (int t = 0; t < ticks; t++) begin
        r = $urandom_range(0, 99);
        if (!full && r < 4) begin
          load_entry($urandom_range(0, 255));
          random_items++;
        end else if (r < 6) begin
          send_op(OP_UNUSED);
        end else if (!full && r < 8) begin
          send_op(OP_START);
          random_items++;
        end else begin
          send_op(OP_TICK);
          random_items++;
        end
      end
      if (full) full_done = 1'b1;
    end

    drain_results();
    $display("ran %0d transactions in %0d phases over %0d register settings", item_count,
             phase_no, settings_count);
    $display("checked %0d setpoint pairs, incl. full 256-entry playback and clamped counts",
             checked_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[hermite_waypoint_interpolator_core] OK");
    end else begin
      $display("[hermite_waypoint_interpolator_core] ERROR");
    end
    $finish;
  end

endmodule
